>>> src/icm_pkg.sv
package icm_pkg;

  // Problem size
  localparam int NUM_BOOKS   = 4;
  localparam int BOOK_SIZE   = 16;
  localparam int BOOK_W      = $clog2(NUM_BOOKS);
  localparam int CODE_W      = $clog2(BOOK_SIZE);
  localparam int TERM_W      = 32;
  localparam int PASS_W      = 5;
  localparam int PASS_RESET  = 4;
  localparam int ACC_W       = TERM_W + $clog2(NUM_BOOKS);
  localparam int PAIR_DEPTH  = NUM_BOOKS * NUM_BOOKS * BOOK_SIZE * BOOK_SIZE;
  localparam int UNARY_DEPTH = NUM_BOOKS * BOOK_SIZE;
  localparam int PAIR_AW     = $clog2(PAIR_DEPTH);
  localparam int UNARY_AW    = $clog2(UNARY_DEPTH);

  // Request modes
  localparam logic [1:0] MODE_PAIR  = 2'd0;
  localparam logic [1:0] MODE_UNARY = 2'd1;
  localparam logic [1:0] MODE_CODE  = 2'd2;
  localparam logic [1:0] MODE_RUN   = 2'd3;

  // Microprogram step addresses
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] ST_CHK   = 4'd1;
  localparam logic [STEP_W-1:0] ST_RD_U  = 4'd2;
  localparam logic [STEP_W-1:0] ST_LD_U  = 4'd3;
  localparam logic [STEP_W-1:0] ST_RD_P  = 4'd4;
  localparam logic [STEP_W-1:0] ST_ADD_P = 4'd5;
  localparam logic [STEP_W-1:0] ST_CMP   = 4'd6;
  localparam logic [STEP_W-1:0] ST_WR    = 4'd7;
  localparam logic [STEP_W-1:0] ST_PASS  = 4'd8;
  localparam logic [STEP_W-1:0] ST_OUT   = 4'd9;
  localparam logic [STEP_W-1:0] ST_END   = 4'd10;

  // Jump conditions: taken -> target, else fall through to next step
  localparam logic [2:0] CND_NONE   = 3'd0;
  localparam logic [2:0] CND_ALWAYS = 3'd1;
  localparam logic [2:0] CND_WAIT   = 3'd2;
  localparam logic [2:0] CND_NOPASS = 3'd3;
  localparam logic [2:0] CND_O_MORE = 3'd4;
  localparam logic [2:0] CND_K_MORE = 3'd5;
  localparam logic [2:0] CND_M_MORE = 3'd6;
  localparam logic [2:0] CND_P_MORE = 3'd7;

  // One control word
  typedef struct packed {
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic              clr_cnt;
    logic              rd_u;
    logic              ld_acc;
    logic              rd_p;
    logic              add_p;
    logic              cmp;
    logic              wr_code;
    logic              inc_p;
    logic              emit;
  } ctl_t;

  // Microprogram ROM
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '0;
    case (step)
      ST_IDLE: begin
        w.cond = CND_WAIT;   w.target = ST_IDLE;  w.clr_cnt = 1'b1;
      end
      ST_CHK: begin
        w.cond = CND_NOPASS; w.target = ST_OUT;
      end
      ST_RD_U: begin
        w.cond = CND_NONE;   w.target = ST_IDLE;  w.rd_u = 1'b1;
      end
      ST_LD_U: begin
        w.cond = CND_NONE;   w.target = ST_IDLE;  w.ld_acc = 1'b1;
      end
      ST_RD_P: begin
        w.cond = CND_NONE;   w.target = ST_IDLE;  w.rd_p = 1'b1;
      end
      ST_ADD_P: begin
        w.cond = CND_O_MORE; w.target = ST_RD_P;  w.add_p = 1'b1;
      end
      ST_CMP: begin
        w.cond = CND_K_MORE; w.target = ST_RD_U;  w.cmp = 1'b1;
      end
      ST_WR: begin
        w.cond = CND_M_MORE; w.target = ST_RD_U;  w.wr_code = 1'b1;
      end
      ST_PASS: begin
        w.cond = CND_P_MORE; w.target = ST_RD_U;  w.inc_p = 1'b1;
      end
      ST_OUT: begin
        w.cond = CND_M_MORE; w.target = ST_OUT;   w.emit = 1'b1;
      end
      ST_END: begin
        w.cond = CND_ALWAYS; w.target = ST_IDLE;
      end
      default: begin
        w.cond = CND_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> src/icm_subcode_refine_unit.sv
// Subcode refinement by iterated conditional modes.
// Input requests: a request is taken when start is high and busy is low.
//   in_mode selects: load one pair term, load one unary term, load one
//   starting code, or run the refinement. Loads keep busy low; out-of-range
//   indexes are dropped.
// Config: cfg_pass_count is written when cfg_valid and cfg_ready are high
//   (cfg_ready is always high); sweeps per run, reset value 4.
// Results: a run produces NUM_BOOKS results, one per cycle on consecutive
//   cycles, each marked by out_valid for one cycle; out_last flags the final
//   book. The receiver cannot stall; results are simply presented.
// Steps: each candidate code costs 11 steps of the microprogram: a unary
//   read, a load of the accumulator, one pair-term read plus add per book,
//   then the compare; both term tables have a single read port and are read
//   one word per step. Each book adds a write-back step and each sweep a
//   pass-count step.
// Reset: control returns to the idle step and pass count to 4; the term
//   tables and codes are not cleared and must be loaded before a run.
module icm_subcode_refine_unit
  import icm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [1:0]         in_book_a,
  input  logic [1:0]         in_book_b,
  input  logic [3:0]         in_code_a,
  input  logic [3:0]         in_code_b,
  input  logic signed [31:0] in_term_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_pass_count,
  output logic               out_valid,
  output logic [1:0]         out_book_index,
  output logic [3:0]         out_chosen_code,
  output logic               out_last
);

  // Sequencer state
  logic [STEP_W-1:0] step_r, step_nxt;
  ctl_t              uc;
  logic              take;

  // Loop counters
  logic [BOOK_W-1:0] m_r, m_nxt;
  logic [BOOK_W-1:0] o_r, o_nxt;
  logic [CODE_W-1:0] k_r, k_nxt;
  logic [PASS_W-1:0] p_r, p_nxt;
  logic [PASS_W-1:0] pass_r;

  // Datapath
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  best_r;
  logic [CODE_W-1:0]        best_code_r;
  logic signed [TERM_W-1:0] pair_rd_r;
  logic signed [TERM_W-1:0] uni_rd_r;
  logic [CODE_W-1:0]        code_r [NUM_BOOKS];
  logic [BOOK_W-1:0]        code_idx;
  logic [CODE_W-1:0]        code_rd;

  // Term tables
  logic signed [TERM_W-1:0] pair_mem [PAIR_DEPTH];
  logic signed [TERM_W-1:0] uni_mem  [UNARY_DEPTH];
  logic [PAIR_AW-1:0]       pair_waddr, pair_raddr;
  logic [UNARY_AW-1:0]      uni_waddr, uni_raddr;

  // Output registers
  logic       out_valid_r;
  logic [1:0] out_book_r;
  logic [3:0] out_code_r;
  logic       out_last_r;

  logic accept;
  logic ld_ok_a, ld_ok_b;
  logic m_last, o_last, k_last, p_last;

  assign busy      = (step_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign uc     = ucode(step_r);
  assign m_last = (m_r == BOOK_W'(NUM_BOOKS - 1));
  assign o_last = (o_r == BOOK_W'(NUM_BOOKS - 1));
  assign k_last = (k_r == CODE_W'(BOOK_SIZE - 1));
  assign p_last = (p_r == pass_r - PASS_W'(1));

  // Load range checks
  assign ld_ok_a = (int'(in_book_a) < NUM_BOOKS) && (int'(in_code_a) < BOOK_SIZE);
  assign ld_ok_b = (int'(in_book_b) < NUM_BOOKS) && (int'(in_code_b) < BOOK_SIZE);

  // Single read port on the code registers
  assign code_idx = uc.emit ? m_r : o_r;
  assign code_rd  = code_r[code_idx];

  // Table addresses
  assign pair_waddr = PAIR_AW'((((int'(in_book_a) * NUM_BOOKS + int'(in_book_b)) * BOOK_SIZE
                      + int'(in_code_a)) * BOOK_SIZE) + int'(in_code_b));
  assign pair_raddr = PAIR_AW'((((int'(m_r) * NUM_BOOKS + int'(o_r)) * BOOK_SIZE
                      + int'(k_r)) * BOOK_SIZE) + int'(code_rd));
  assign uni_waddr  = UNARY_AW'(int'(in_book_a) * BOOK_SIZE + int'(in_code_a));
  assign uni_raddr  = UNARY_AW'(int'(m_r) * BOOK_SIZE + int'(k_r));

  // Jump condition
  always_comb begin
    case (uc.cond)
      CND_NONE:   take = 1'b0;
      CND_ALWAYS: take = 1'b1;
      CND_WAIT:   take = !(start && (in_mode == MODE_RUN));
      CND_NOPASS: take = (pass_r == '0);
      CND_O_MORE: take = !o_last;
      CND_K_MORE: take = !k_last;
      CND_M_MORE: take = !m_last;
      CND_P_MORE: take = !p_last;
      default:    take = 1'b1;
    endcase
  end

  assign step_nxt = take ? uc.target : step_r + STEP_W'(1);

  // Counter updates
  always_comb begin
    m_nxt = m_r;
    o_nxt = o_r;
    k_nxt = k_r;
    p_nxt = p_r;
    if (uc.clr_cnt) begin
      m_nxt = '0;
      o_nxt = '0;
      k_nxt = '0;
      p_nxt = '0;
    end
    if (uc.rd_u) begin
      o_nxt = '0;
    end
    if (uc.add_p) begin
      o_nxt = o_last ? '0 : o_r + BOOK_W'(1);
    end
    if (uc.cmp) begin
      k_nxt = k_last ? '0 : k_r + CODE_W'(1);
    end
    if (uc.wr_code || uc.emit) begin
      m_nxt = m_last ? '0 : m_r + BOOK_W'(1);
    end
    if (uc.inc_p) begin
      p_nxt = p_r + PASS_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      m_r         <= '0;
      o_r         <= '0;
      k_r         <= '0;
      p_r         <= '0;
      pass_r      <= PASS_W'(PASS_RESET);
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      m_r         <= m_nxt;
      o_r         <= o_nxt;
      k_r         <= k_nxt;
      p_r         <= p_nxt;
      out_valid_r <= uc.emit;
      if (cfg_valid && cfg_ready) begin
        pass_r <= cfg_pass_count;
      end
    end
  end

  // Pair term table: load write, registered read
  always_ff @(posedge clk) begin
    if (accept && (in_mode == MODE_PAIR) && ld_ok_a && ld_ok_b) begin
      pair_mem[pair_waddr] <= in_term_value;
    end
    if (uc.rd_p) begin
      pair_rd_r <= pair_mem[pair_raddr];
    end
  end

  // Unary term table: load write, registered read
  always_ff @(posedge clk) begin
    if (accept && (in_mode == MODE_UNARY) && ld_ok_a) begin
      uni_mem[uni_waddr] <= in_term_value;
    end
    if (uc.rd_u) begin
      uni_rd_r <= uni_mem[uni_raddr];
    end
  end

  // Accumulate, compare, current codes, result payload
  always_ff @(posedge clk) begin
    if (uc.ld_acc) begin
      acc_r <= ACC_W'(uni_rd_r);
    end
    if (uc.add_p && (o_r != m_r)) begin
      acc_r <= acc_r + ACC_W'(pair_rd_r);
    end
    // first candidate always wins; ties keep the lower code
    if (uc.cmp && ((k_r == '0) || (acc_r < best_r))) begin
      best_r      <= acc_r;
      best_code_r <= k_r;
    end
    if (accept && (in_mode == MODE_CODE) && ld_ok_a) begin
      code_r[BOOK_W'(in_book_a)] <= CODE_W'(in_code_a);
    end
    if (uc.wr_code) begin
      code_r[m_r] <= best_code_r;
    end
    if (uc.emit) begin
      out_book_r <= 2'(m_r);
      out_code_r <= 4'(code_rd);
      out_last_r <= m_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_book_index  = out_book_r;
  assign out_chosen_code = out_code_r;
  assign out_last        = out_last_r;

`ifndef NO_ASSERTIONS
  // A result strobe only follows an emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(step_r == ST_OUT))
    else $error("result strobe without emit step");

  // Results of one run come back to back in book order
  a_book_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_book_index == $past(out_book_index) + 2'd1))
    else $error("result sequence broken");

  // Nothing follows the last result
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result after last");

  // An accepted run makes the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == MODE_RUN) |=> busy)
    else $error("run request not started");
`endif

endmodule
